[src/cta_pkg.sv]
// Shared types and constants for the child table with aging.
package cta_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 10;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Field widths fixed by the interface
    localparam int ADDR_W = 16;
    localparam int AGE_W  = 16;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(45);

    // Request codes
    localparam logic [1:0] REQ_KEEPALIVE = 2'd0;
    localparam logic [1:0] REQ_TICK      = 2'd1;
    localparam logic [1:0] REQ_SWEEP     = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_TICK      = 3'd3,
        ST_SWEEP     = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    // Input word
    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] child_address;
    } t_in_word;

    // Result word
    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  removed_count;
    } t_out_word;

    // Table write request
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [AGE_W-1:0]  age;
    } t_tbl_wr;

    // Per-slot verdict of the shared compare unit
    typedef struct packed {
        logic             hit;
        logic             free;
        logic             expire;
        logic [AGE_W-1:0] new_age;
    } t_unit_res;

endpackage

[src/cta_table.sv]
// Slot storage: address and age registers, one read and one write port.
module cta_table
    import cta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [ADDR_W-1:0] o_rd_addr,
    output logic [AGE_W-1:0]  o_rd_age,
    input  t_tbl_wr           i_wr
);

    logic [ADDR_W-1:0] r_addr [TABLE_SLOTS];
    logic [AGE_W-1:0]  r_age  [TABLE_SLOTS];

    // Cleared at reset: address zero marks a free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                r_addr[k] <= '0;
                r_age[k]  <= '0;
            end
        end else if (i_wr.en) begin
            r_addr[i_wr.idx] <= i_wr.addr;
            r_age[i_wr.idx]  <= i_wr.age;
        end
    end

    assign o_rd_addr = r_addr[i_rd_idx];
    assign o_rd_age  = r_age[i_rd_idx];

endmodule

[src/cta_unit.sv]
// Shared slot unit: address compare, age increment and timeout compare.
module cta_unit
    import cta_pkg::*;
(
    input  logic [1:0]        i_req,
    input  logic [ADDR_W-1:0] i_key,
    input  logic [ADDR_W-1:0] i_entry_addr,
    input  logic [AGE_W-1:0]  i_entry_age,
    input  logic [AGE_W-1:0]  i_timeout,
    output t_unit_res         o_res
);

    logic occupied;
    logic below;

    assign occupied = (i_entry_addr != '0);
    assign below    = (i_entry_age < i_timeout);

    always_comb begin
        o_res = '0;
        o_res.new_age = i_entry_age;
        case (i_req)
            REQ_KEEPALIVE: begin
                // key is never zero here, so a free slot cannot hit
                o_res.hit  = (i_entry_addr == i_key);
                o_res.free = !occupied;
            end
            REQ_TICK: begin
                // saturate at the timeout; free slots stay at zero
                if (occupied && below) begin
                    o_res.new_age = i_entry_age + AGE_W'(1);
                end
            end
            REQ_SWEEP: begin
                o_res.expire = occupied && !below;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

[src/child_table_with_aging_core.sv]
// Top level: request sequencer walking the child table through one shared unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one request word:
//   keep-alive, tick or sweep. Output channel (o_out_valid / i_out_stall /
//   o_out_word) returns exactly one result word per request.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the timeout;
//   it is always ready and should be used only while the block is idle.
// Sequencing:
//   A request walks the slots one per cycle through a single compare/increment
//   unit in the walk state, then hands its result on in the done state. A
//   keep-alive that hits stops early; an ignored request (address zero or
//   unknown type) skips the walk. One request is in work at a time, and
//   o_in_stall is high until its result is in the output register.
// Reset:
//   Synchronous, active low: the table is cleared (all slots free, ages zero),
//   the timeout returns to 45 and no result is pending.
// Stall:
//   The result sits in an output register; a new request may be accepted while
//   it waits. A finished request holds in its final state until that register
//   is taken.
module child_table_with_aging_core
    import cta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [AGE_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    t_state            r_state,      n_state;
    logic [IDX_W-1:0]  r_idx,        n_idx;
    logic [1:0]        r_req,        n_req;
    logic [ADDR_W-1:0] r_key,        n_key;
    logic              r_free_ok,    n_free_ok;
    logic [IDX_W-1:0]  r_free_idx,   n_free_idx;
    logic [CNT_W-1:0]  r_removed,    n_removed;
    t_status           r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_slot,   n_res_slot;
    logic              r_out_valid,  n_out_valid;
    t_out_word         r_out_word,   n_out_word;
    logic [AGE_W-1:0]  r_timeout,    n_timeout;

    logic [ADDR_W-1:0] rd_addr;
    logic [AGE_W-1:0]  rd_age;
    t_unit_res         unit_res;
    t_tbl_wr           tbl_wr;
    logic              in_accept;
    logic              out_take;
    logic              last;

    cta_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_idx),
        .o_rd_addr (rd_addr),
        .o_rd_age  (rd_age),
        .i_wr      (tbl_wr)
    );

    cta_unit u_unit (
        .i_req        (r_req),
        .i_key        (r_key),
        .i_entry_addr (rd_addr),
        .i_entry_age  (rd_age),
        .i_timeout    (r_timeout),
        .o_res        (unit_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;
    assign last        = (r_idx == LAST_IDX);

    // Sequencer next state and table write
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_req        = r_req;
        n_key        = r_key;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_removed    = r_removed;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_timeout    = r_timeout;
        tbl_wr       = '0;

        if (i_cfg_valid) begin
            n_timeout = i_cfg_data;
        end

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req      = i_in_word.req_type;
                    n_key      = i_in_word.child_address;
                    n_idx      = '0;
                    n_free_ok  = 1'b0;
                    n_removed  = '0;
                    n_res_slot = '0;
                    if ((i_in_word.req_type == REQ_KEEPALIVE &&
                         i_in_word.child_address != '0) ||
                        i_in_word.req_type == REQ_TICK ||
                        i_in_word.req_type == REQ_SWEEP) begin
                        n_state = S_WALK;
                    end else begin
                        n_res_status = ST_IGNORED;
                        n_state      = S_DONE;
                    end
                end
            end
            S_WALK: begin
                n_idx = r_idx + IDX_W'(1);
                case (r_req)
                    REQ_TICK: begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.idx  = r_idx;
                        tbl_wr.addr = rd_addr;
                        tbl_wr.age  = unit_res.new_age;
                        if (last) begin
                            n_res_status = ST_TICK;
                            n_state      = S_DONE;
                        end
                    end
                    REQ_SWEEP: begin
                        // freed slot gets address and age zero
                        tbl_wr.en  = unit_res.expire;
                        tbl_wr.idx = r_idx;
                        if (unit_res.expire) begin
                            n_removed = r_removed + CNT_W'(1);
                        end
                        if (last) begin
                            n_res_status = ST_SWEEP;
                            n_state      = S_DONE;
                        end
                    end
                    default: begin
                        // keep-alive: stop on hit, remember lowest free slot
                        if (unit_res.hit) begin
                            tbl_wr.en    = 1'b1;
                            tbl_wr.idx   = r_idx;
                            tbl_wr.addr  = rd_addr;
                            n_res_status = ST_REFRESHED;
                            n_res_slot   = SLOT_W'(r_idx);
                            n_state      = S_DONE;
                        end else begin
                            if (unit_res.free && !r_free_ok) begin
                                n_free_ok  = 1'b1;
                                n_free_idx = r_idx;
                            end
                            if (last) begin
                                if (n_free_ok) begin
                                    tbl_wr.en    = 1'b1;
                                    tbl_wr.idx   = n_free_idx;
                                    tbl_wr.addr  = r_key;
                                    n_res_status = ST_ADDED;
                                    n_res_slot   = SLOT_W'(n_free_idx);
                                end else begin
                                    n_res_status = ST_FULL;
                                end
                                n_state = S_DONE;
                            end
                        end
                    end
                endcase
            end
            S_DONE: begin
                // hand result to the output register once it is free
                if (!r_out_valid || out_take) begin
                    n_out_valid              = 1'b1;
                    n_out_word.status        = r_res_status;
                    n_out_word.slot_index    = r_res_slot;
                    n_out_word.removed_count = r_removed;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
            r_idx       <= '0;
            r_free_ok   <= 1'b0;
            r_removed   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_timeout   <= n_timeout;
            r_idx       <= n_idx;
            r_free_ok   <= n_free_ok;
            r_removed   <= n_removed;
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_word   <= n_out_word;
    end

endmodule
